/* src/ccms_pkg.sv */
package ccms_pkg;

    // Item kinds carried on the input tuser.
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_TICK = 2'd0;
    localparam mode_t MODE_SET  = 2'd1;
    localparam mode_t MODE_READ = 2'd2;

    localparam logic [9:0]  MILLIS_LAST = 10'd999;
    localparam logic [5:0]  SECOND_LAST = 6'd59;
    localparam logic [5:0]  MINUTE_LAST = 6'd59;
    localparam logic [4:0]  HOUR_LAST   = 5'd23;
    localparam logic [3:0]  MONTH_LAST  = 4'd12;
    localparam logic [15:0] YEAR_MIN    = 16'd2000;
    localparam logic [15:0] YEAR_MAX    = 16'd2099;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 88;

    // Calendar state; the last member sits in the lowest bits.
    typedef struct packed {
        logic [31:0] uptime;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millis;
    } cal_t;

    // Fields of a set request, packed the same way as on the input tdata.
    typedef struct packed {
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [9:0]  millis;
    } set_req_t;

    // Length of a month; February gains a day when the year is a multiple of four.
    // Codes outside one to twelve give zero.
    function automatic logic [4:0] month_days(input logic [3:0] month,
                                              input logic [1:0] year_lo);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = (year_lo == 2'd0) ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* src/ccms_step.sv */
module ccms_step (
    input  ccms_pkg::cal_t     cal_cur,
    input  ccms_pkg::mode_t    mode,
    input  ccms_pkg::set_req_t set_req,
    output ccms_pkg::cal_t     cal_new,
    output logic               set_ok
);
    import ccms_pkg::*;

    cal_t       cal_tick;
    logic       set_valid;
    logic [4:0] cur_len;
    logic [4:0] set_len;

    assign cur_len = month_days(cal_cur.month, cal_cur.year[1:0]);
    assign set_len = month_days(set_req.month[3:0], set_req.year[1:0]);

    // Cascaded counters: each stage steps only when every lower stage wraps.
    always_comb begin
        cal_tick        = cal_cur;
        cal_tick.uptime = cal_cur.uptime + 32'd1;
        if (cal_cur.millis < MILLIS_LAST) begin
            cal_tick.millis = cal_cur.millis + 10'd1;
        end else begin
            cal_tick.millis = '0;
            if (cal_cur.second < SECOND_LAST) begin
                cal_tick.second = cal_cur.second + 6'd1;
            end else begin
                cal_tick.second = '0;
                if (cal_cur.minute < MINUTE_LAST) begin
                    cal_tick.minute = cal_cur.minute + 6'd1;
                end else begin
                    cal_tick.minute = '0;
                    if (cal_cur.hour < HOUR_LAST) begin
                        cal_tick.hour = cal_cur.hour + 5'd1;
                    end else begin
                        cal_tick.hour = '0;
                        if (cal_cur.day < cur_len) begin
                            cal_tick.day = cal_cur.day + 5'd1;
                        end else begin
                            cal_tick.day = 5'd1;
                            if (cal_cur.month < MONTH_LAST) begin
                                cal_tick.month = cal_cur.month + 4'd1;
                            end else begin
                                cal_tick.month = 4'd1;
                                cal_tick.year  = cal_cur.year + 16'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    assign set_valid = (set_req.second <= {2'b00, SECOND_LAST})
                    && (set_req.minute <= {2'b00, MINUTE_LAST})
                    && (set_req.hour   <= {3'b000, HOUR_LAST})
                    && (set_req.day    != 8'd0)
                    && (set_req.month  != 8'd0)
                    && (set_req.month  <= {4'b0000, MONTH_LAST})
                    && (set_req.year   >= YEAR_MIN)
                    && (set_req.year   <= YEAR_MAX)
                    && (set_req.day    <= {3'b000, set_len});

    always_comb begin
        cal_new = cal_cur;
        set_ok  = 1'b0;
        case (mode)
            MODE_TICK: begin
                cal_new = cal_tick;
            end
            MODE_SET: begin
                if (set_valid) begin
                    cal_new.millis = set_req.millis;
                    cal_new.second = set_req.second[5:0];
                    cal_new.minute = set_req.minute[5:0];
                    cal_new.hour   = set_req.hour[4:0];
                    cal_new.day    = set_req.day[4:0];
                    cal_new.month  = set_req.month[3:0];
                    cal_new.year   = set_req.year;
                    set_ok         = 1'b1;
                end
            end
            default: begin
                cal_new = cal_cur;
            end
        endcase
    end

endmodule

/* src/calendar_clock_ms_core.sv */
// Channel   Direction  Ports                               Contents
// s_        in         s_tvalid s_tready s_tdata s_tuser   set fields, item kind
// m_        out        m_tvalid m_tready m_tdata m_tuser   time after item, set flag
//
// Every item passes from its input transfer into the input register, then through
// the calendar update into the result register. One item per cycle is sustained
// while m_tready is high; the calendar counters are the only loop.
// Reset (aresetn low at a clock edge) sets 2000-01-01 00:00:00.000, uptime zero.
// A stalled result holds the result register, and the input register keeps
// taking a transfer whenever its item moves on in the same cycle.
module calendar_clock_ms_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Lowest bit up: set_millis 10, set_second 8, set_minute 8, set_hour 8,
    // set_day 8, set_month 8, set_year 16, zero fill 6.
    input  logic [ccms_pkg::S_TDATA_W-1:0]      s_tdata,
    // mode 2.
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Lowest bit up: millis_out 10, second_out 6, minute_out 6, hour_out 5,
    // day_out 5, month_out 4, year_out 16, uptime_out 32, zero fill 4.
    output logic [ccms_pkg::M_TDATA_W-1:0]      m_tdata,
    // set_ok 1.
    output logic                                m_tuser
);
    import ccms_pkg::*;

    // Input register: one item waiting for its calendar update.
    logic     in_vld_reg, in_vld_next;
    mode_t    in_mode_reg;
    set_req_t in_req_reg;

    // Calendar state, which always reflects every item already moved to the output.
    cal_t     cal_reg;
    cal_t     cal_next;
    logic     set_ok_next;

    // Result register.
    logic     out_vld_reg, out_vld_next;
    cal_t     out_cal_reg;
    logic     out_ok_reg;

    logic     s_xfer;
    logic     advance;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    ccms_step u_step (
        .cal_cur (cal_reg),
        .mode    (in_mode_reg),
        .set_req (in_req_reg),
        .cal_new (cal_next),
        .set_ok  (set_ok_next)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_xfer) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            cal_reg     <= '{uptime: 32'd0, year: YEAR_MIN, month: 4'd1, day: 5'd1,
                             hour: 5'd0, minute: 6'd0, second: 6'd0, millis: 10'd0};
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance) begin
                cal_reg <= cal_next;
            end
        end
    end

    // Payload registers need no reset; their valid flags guard them.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_mode_reg <= s_tuser;
            in_req_reg  <= s_tdata[$bits(set_req_t)-1:0];
        end
        if (advance) begin
            out_cal_reg <= cal_next;
            out_ok_reg  <= set_ok_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(cal_t)){1'b0}}, out_cal_reg};
    assign m_tuser  = out_ok_reg;

    // The day counter never reaches zero and the month counter stays within one to twelve.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cal_reg.day != 5'd0) && (cal_reg.month != 4'd0)
        && (cal_reg.month <= MONTH_LAST))
        else $error("calendar day or month out of range");

    // A tick moving on advances the uptime by exactly one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_mode_reg == MODE_TICK)
        |=> cal_reg.uptime == $past(cal_reg.uptime) + 32'd1)
        else $error("uptime did not step on a tick");

    // Anything other than a tick leaves the uptime alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_mode_reg != MODE_TICK) |=> $stable(cal_reg.uptime))
        else $error("uptime changed on a set or read");

    // An applied set leaves a year inside the accepted window.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_ok_reg
        |-> (out_cal_reg.year >= YEAR_MIN) && (out_cal_reg.year <= YEAR_MAX))
        else $error("set flagged with year outside window");

    // The shown result matches the calendar state behind it while no item waits in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !in_vld_reg |-> out_cal_reg == cal_reg)
        else $error("result register diverged from calendar state");

endmodule

/* test/tb_calendar_clock_ms_core.sv */
`timescale 1ns / 1ps

module tb_calendar_clock_ms_core;
    import ccms_pkg::*;

    // Mode 3 is not named by the block; it behaves like a read.
    localparam mode_t MODE_SPARE = 2'd3;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 60;
    localparam int RANDOM_ITEMS = 1700;
    localparam int QUIET_ITEMS  = 300;

    localparam logic [4:0] MONTH_LEN [0:15] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    typedef struct {
        cal_t cal;
        logic ok;
    } time_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = MODE_READ;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    cal_t         calendar;
    time_result_t pending_times[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           items_sent     = 0;
    bit           idle_on        = 1'b0;
    bit           hold_req       = 1'b0;

    calendar_clock_ms_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Calendar predictor
    // ---------------------------------------------------------------

    function automatic logic [4:0] month_length(input logic [3:0] mon, input logic [15:0] yr);
        logic [4:0] n;
        n = MONTH_LEN[mon];
        if (mon == 4'd2 && yr[1:0] == 2'b00) n = n + 5'd1;
        return n;
    endfunction

    // One millisecond step; each counter only moves when all lower ones wrap.
    function automatic cal_t ticked(input cal_t c);
        cal_t n;
        n = c;
        n.uptime = c.uptime + 32'd1;
        if (c.millis < MILLIS_LAST) begin
            n.millis = c.millis + 10'd1;
        end else begin
            n.millis = '0;
            if (c.second < SECOND_LAST) begin
                n.second = c.second + 6'd1;
            end else begin
                n.second = '0;
                if (c.minute < MINUTE_LAST) begin
                    n.minute = c.minute + 6'd1;
                end else begin
                    n.minute = '0;
                    if (c.hour < HOUR_LAST) begin
                        n.hour = c.hour + 5'd1;
                    end else begin
                        n.hour = '0;
                        if (c.day < month_length(c.month, c.year)) begin
                            n.day = c.day + 5'd1;
                        end else begin
                            n.day = 5'd1;
                            if (c.month < MONTH_LAST) begin
                                n.month = c.month + 4'd1;
                            end else begin
                                n.month = 4'd1;
                                n.year  = c.year + 16'd1;
                            end
                        end
                    end
                end
            end
        end
        return n;
    endfunction

    function automatic bit set_is_valid(input set_req_t r);
        if (r.second > 8'd59 || r.minute > 8'd59 || r.hour > 8'd23) return 1'b0;
        if (r.day < 8'd1 || r.month < 8'd1 || r.month > 8'd12) return 1'b0;
        if (r.year < YEAR_MIN || r.year > YEAR_MAX) return 1'b0;
        return r.day <= month_length(r.month[3:0], r.year);
    endfunction

    // Updates the calendar for one accepted item and queues the time it reports.
    task automatic apply_to_calendar(input mode_t mode, input set_req_t r);
        time_result_t res;
        res.ok = 1'b0;
        if (mode == MODE_TICK) begin
            calendar = ticked(calendar);
        end else if (mode == MODE_SET && set_is_valid(r)) begin
            calendar.millis = r.millis;
            calendar.second = r.second[5:0];
            calendar.minute = r.minute[5:0];
            calendar.hour   = r.hour[4:0];
            calendar.day    = r.day[4:0];
            calendar.month  = r.month[3:0];
            calendar.year   = r.year;
            res.ok = 1'b1;
        end
        res.cal = calendar;
        pending_times.push_back(res);
    endtask

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        time_result_t want;
        cal_t         got;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_times.size() == 0) begin
                $error("result transfer with no expected time waiting");
                mismatch_count++;
            end else begin
                want = pending_times.pop_front();
                got  = cal_t'(m_tdata[$bits(cal_t)-1:0]);
                compare_field("millis_out", 32'(want.cal.millis), 32'(got.millis));
                compare_field("second_out", 32'(want.cal.second), 32'(got.second));
                compare_field("minute_out", 32'(want.cal.minute), 32'(got.minute));
                compare_field("hour_out",   32'(want.cal.hour),   32'(got.hour));
                compare_field("day_out",    32'(want.cal.day),    32'(got.day));
                compare_field("month_out",  32'(want.cal.month),  32'(got.month));
                compare_field("year_out",   32'(want.cal.year),   32'(got.year));
                compare_field("uptime_out", want.cal.uptime,      got.uptime);
                compare_field("set_ok",     32'(want.ok),         32'(m_tuser));
            end
        end
    end

    // ---------------------------------------------------------------
    // Result receiver: random stalls, plus one long hold-off on request
    // ---------------------------------------------------------------

    initial begin
        int hold_left;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0) begin
                    @(posedge aclk);
                    hold_left--;
                end
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Offers one item and returns at the edge where its transfer happens.
    task automatic send_item(input mode_t mode, input set_req_t r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_TDATA_W - $bits(set_req_t)){1'b0}}, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_to_calendar(mode, r);
        items_sent++;
    endtask

    task automatic send_set(input int unsigned yr, input int unsigned mon, input int unsigned dy,
                            input int unsigned hr, input int unsigned mi, input int unsigned se,
                            input int unsigned ms);
        set_req_t r;
        r.year   = 16'(yr);
        r.month  = 8'(mon);
        r.day    = 8'(dy);
        r.hour   = 8'(hr);
        r.minute = 8'(mi);
        r.second = 8'(se);
        r.millis = 10'(ms);
        send_item(MODE_SET, r);
    endtask

    task automatic send_plain(input mode_t mode);
        send_item(mode, set_req_t'({$urandom, $urandom, $urandom}));
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_times.size() != 0) @(posedge aclk);
    endtask

    // A valid set parked close to a rollover; depth picks how many counters carry.
    function automatic set_req_t near_rollover();
        set_req_t r;
        int       depth;
        depth    = $urandom_range(0, 6);
        r.year   = (depth == 6) ? YEAR_MAX : YEAR_MIN + 16'($urandom_range(0, 99));
        r.month  = (depth >= 5) ? 8'd12 : 8'($urandom_range(1, 12));
        r.day    = (depth >= 4) ? 8'(month_length(r.month[3:0], r.year))
                                : 8'($urandom_range(1, month_length(r.month[3:0], r.year)));
        r.hour   = (depth >= 3) ? 8'd23 : 8'($urandom_range(0, 23));
        r.minute = (depth >= 2) ? 8'd59 : 8'($urandom_range(0, 59));
        r.second = (depth >= 1) ? 8'd59 : 8'($urandom_range(0, 59));
        r.millis = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                               : 10'($urandom_range(990, 1023));
        return r;
    endfunction

    // Knocks one field of a valid set outside its legal range.
    function automatic set_req_t broken_set(input set_req_t r);
        case ($urandom_range(0, 5))
            0: r.second = 8'($urandom_range(60, 255));
            1: r.minute = 8'($urandom_range(60, 255));
            2: r.hour   = 8'($urandom_range(24, 255));
            3: r.day    = ($urandom_range(0, 1) == 0)
                          ? 8'd0 : 8'(month_length(r.month[3:0], r.year)) + 8'd1;
            4: r.month  = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(13, 255));
            default: r.year = ($urandom_range(0, 1) == 0)
                              ? 16'($urandom_range(0, 1999)) : 16'($urandom_range(2100, 65535));
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_reset_and_modes();
        send_plain(MODE_READ);
        send_plain(MODE_SPARE);
        send_plain(MODE_TICK);
        wait_all_results();
    endtask

    task automatic test_rollovers();
        send_set(2099, 12, 31, 23, 59, 59, 999);
        send_plain(MODE_TICK);
        send_set(2024, 2, 28, 23, 59, 59, 1023);
        send_plain(MODE_TICK);
        send_plain(MODE_TICK);
        send_set(2023, 2, 28, 23, 59, 59, 999);
        send_plain(MODE_TICK);
        send_set(2023, 2, 29, 0, 0, 0, 0);
        send_set(2024, 2, 29, 0, 0, 0, 0);
        send_set(2000, 4, 30, 23, 59, 59, 999);
        send_plain(MODE_TICK);
        send_set(2000, 4, 31, 0, 0, 0, 0);
        wait_all_results();
    endtask

    task automatic test_set_rejects();
        send_set(1999, 6, 15, 12, 30, 30, 500);
        send_set(2100, 6, 15, 12, 30, 30, 500);
        send_set(2050, 0, 15, 12, 30, 30, 500);
        send_set(2050, 13, 15, 12, 30, 30, 500);
        send_set(2050, 6, 0, 12, 30, 30, 500);
        send_set(2050, 6, 15, 12, 30, 60, 500);
        send_set(2050, 6, 15, 12, 60, 30, 500);
        send_set(2050, 6, 15, 24, 30, 30, 500);
        send_set(65535, 255, 255, 255, 255, 255, 1023);
        send_set(2000, 1, 1, 0, 0, 0, 0);
        send_plain(MODE_READ);
        wait_all_results();
    endtask

    // The receiver stops for a long stretch while items keep coming, so the
    // block fills and has to push back on its input.
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (30) send_plain(($urandom_range(0, 1) == 0) ? MODE_TICK : MODE_READ);
        wait_all_results();
    endtask

    // Mostly valid sets near a rollover followed by a run of ticks, the rest
    // broken sets, raw sets and stray items of any mode.
    task automatic random_episode();
        set_req_t r;
        int       kind;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            send_item(MODE_SET, near_rollover());
            repeat ($urandom_range(1, 8)) send_plain(MODE_TICK);
            if ($urandom_range(0, 3) == 0) send_plain(MODE_READ);
        end else if (kind < 8) begin
            r = near_rollover();
            send_item(MODE_SET, broken_set(r));
            send_plain(MODE_TICK);
        end else if (kind == 8) begin
            send_item(MODE_SET, set_req_t'({$urandom, $urandom, $urandom}));
        end else begin
            send_plain(mode_t'($urandom_range(0, 3)));
        end
    endtask

    task automatic test_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) random_episode();
    endtask

    initial begin
        calendar = '{uptime: 32'd0, year: YEAR_MIN, month: 4'd1, day: 5'd1,
                     hour: 5'd0, minute: 6'd0, second: 6'd0, millis: 10'd0};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_and_modes();
        test_rollovers();
        test_set_rejects();
        test_backpressure();

        idle_on = 1'b1;
        test_random((RANDOM_ITEMS - QUIET_ITEMS) / 2);
        wait_all_results();
        test_random((RANDOM_ITEMS - QUIET_ITEMS) / 2);

        // Closing stretch runs at full rate on both sides.
        idle_on = 1'b0;
        test_random(QUIET_ITEMS);

        wait_all_results();
        repeat (5) @(posedge aclk);
        if (mismatch_count == 0 && pending_times.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
